// File: rtl/jslc_pkg.sv
// Shared types and codes for the JSON structure limit checker.
package jslc_pkg;

  typedef enum logic [3:0] {
    ACT_BEGIN      = 4'd0,
    ACT_SCALAR     = 4'd1,
    ACT_STRING     = 4'd2,
    ACT_KEY        = 4'd3,
    ACT_OPEN_OBJ   = 4'd4,
    ACT_OPEN_ARR   = 4'd5,
    ACT_CLOSE_OBJ  = 4'd6,
    ACT_CLOSE_ARR  = 4'd7,
    ACT_BINARY     = 4'd8,
    ACT_SYNTAX     = 4'd9
  } action_e;

  typedef enum logic [3:0] {
    FAIL_NONE       = 4'd0,
    FAIL_BAD_LIMITS = 4'd1,
    FAIL_TOO_LARGE  = 4'd2,
    FAIL_BINARY     = 4'd3,
    FAIL_KEY_PLACE  = 4'd4,
    FAIL_ITEMS      = 4'd5,
    FAIL_NODES      = 4'd6,
    FAIL_STRING     = 4'd7,
    FAIL_TOTAL_STR  = 4'd8,
    FAIL_DEPTH      = 4'd9,
    FAIL_MISMATCH   = 4'd10,
    FAIL_SYNTAX     = 4'd11
  } fail_e;

  typedef enum logic [2:0] {
    REG_MAX_BYTES       = 3'd0,
    REG_MAX_DEPTH       = 3'd1,
    REG_MAX_NODES       = 3'd2,
    REG_MAX_ITEMS       = 3'd3,
    REG_MAX_STRING      = 3'd4,
    REG_MAX_TOTAL_STR   = 3'd5
  } cfg_reg_e;

  localparam int unsigned CfgIdxBits  = 3;
  localparam int unsigned CfgDataBits = 32;

  localparam logic [31:0] RstMaxBytes    = 32'd1048576;
  localparam logic [6:0]  RstMaxDepth    = 7'd64;
  localparam logic [31:0] RstMaxNodes    = 32'd65536;
  localparam logic [31:0] RstMaxItems    = 32'd4096;
  localparam logic [31:0] RstMaxString   = 32'd65536;
  localparam logic [31:0] RstMaxTotalStr = 32'd1048576;

  typedef struct packed {
    logic [3:0]  action;
    logic [31:0] length;
    logic [31:0] declared_count;
    logic        count_known;
    logic [31:0] position;
  } in_item_t;

  typedef struct packed {
    logic        ok;
    logic [3:0]  fail_code;
    logic [31:0] fail_position;
  } out_item_t;

endpackage

// File: rtl/jslc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module jslc_ram #(
  parameter int unsigned WIDTH = 33,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/json_structure_limit_checker.sv
// Top level of the JSON structure limit checker: event checks, frame stack and result stage.
//
// Usage: the producer sends one parsed JSON event per transfer on the input
// channel (in_valid_i / in_stall_o, payload in_data_i). Every accepted event
// yields exactly one status transfer on the output channel (out_valid_o /
// out_stall_i, payload out_data_o): ok, the first failure code and the byte
// offset recorded with a syntax failure.
// The status of each accepted event is registered. Throughput is one event per
// cycle while in_stall_o is low; the checks read only the top frame and the
// scalar counters, which sit in registers, and the frames below live in a RAM
// with a one-frame read-ahead register, so pops and pushes run back to back.
// A two-entry result stage (output register plus skid register) lets the
// block take one more event while the receiver stalls; in_stall_o rises
// once both entries are full and falls as soon as the receiver takes one.
// Limits are written over cfg_we_i / cfg_idx_i / cfg_wdata_i while no event
// is in flight; indexes beyond the register list are ignored.
// Reset loads the default limits, empties the stack, clears all counters and
// the failure, and drops any pending result. A begin event does the same for
// the document state and then checks the limits and the document size.
module json_structure_limit_checker #(
  parameter int unsigned STACK_DEPTH = 64,
  parameter int unsigned COUNT_BITS  = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  jslc_pkg::in_item_t                   in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output jslc_pkg::out_item_t                  out_data_o,
  input  logic                                 cfg_we_i,
  input  logic [jslc_pkg::CfgIdxBits-1:0]      cfg_idx_i,
  input  logic [jslc_pkg::CfgDataBits-1:0]     cfg_wdata_i
);

  localparam int unsigned DW  = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned XW  = (DW > 7) ? DW : 7;
  localparam int unsigned LW  = (COUNT_BITS > 32) ? COUNT_BITS : 32;
  localparam int unsigned FW  = COUNT_BITS + 1;
  localparam logic [LW-1:0] CNT_MAX = (LW'(1) << COUNT_BITS) - LW'(1);

  // limit registers
  logic [31:0] max_bytes_q, max_nodes_q, max_items_q, max_str_q, max_total_q;
  logic [6:0]  max_depth_q;

  // document state
  logic [DW-1:0]         depth_q, depth_d;
  logic [COUNT_BITS-1:0] node_q, node_d;
  logic [COUNT_BITS-1:0] str_q, str_d;
  jslc_pkg::fail_e       fail_q, fail_d;
  logic [31:0]           offs_q, offs_d;
  logic                  top_arr_q, top_arr_d;
  logic [COUNT_BITS-1:0] top_items_q, top_items_d;
  logic [FW-1:0]         under_q, under_d;
  logic                  under_ram_q, under_ram_d;

  // result stage
  logic                  ov_q, sv_q;
  jslc_pkg::out_item_t   out_q, skid_q, res;

  logic                  in_fire, out_fire;
  logic                  ram_we, ram_re;
  logic [AW-1:0]         ram_waddr, ram_raddr;
  logic [FW-1:0]         ram_wdata, ram_rdata, under_val;

  logic [LW-1:0]         eff_nodes, eff_items, eff_total;
  logic                  node_ok, items_ok, bump_top, depth_full, bad_limits;
  logic [COUNT_BITS-1:0] items_bumped;
  logic [LW:0]           str_sum;
  jslc_pkg::fail_e       cv_code, text_code;
  logic                  is_arr_op;

  assign in_fire  = in_valid_i && !sv_q;
  assign out_fire = ov_q && !out_stall_i;

  // limits clipped to the counter range
  always_comb begin
    eff_nodes = (LW'(max_nodes_q) > CNT_MAX) ? CNT_MAX : LW'(max_nodes_q);
    eff_items = (LW'(max_items_q) > CNT_MAX) ? CNT_MAX : LW'(max_items_q);
    eff_total = (LW'(max_total_q) > CNT_MAX) ? CNT_MAX : LW'(max_total_q);
  end

  assign under_val    = under_ram_q ? ram_rdata : under_q;
  assign node_ok      = LW'(node_q) < eff_nodes;
  assign items_ok     = LW'(top_items_q) < eff_items;
  assign bump_top     = (depth_q != '0) && top_arr_q;
  assign items_bumped = bump_top ? top_items_q + COUNT_BITS'(1) : top_items_q;
  assign str_sum      = (LW + 1)'(in_data_i.length) + (LW + 1)'(str_q);
  assign depth_full   = (XW'(depth_q) >= XW'(max_depth_q)) ||
                        (XW'(depth_q) >= XW'(STACK_DEPTH));
  assign bad_limits   = (max_bytes_q == '0) || (max_depth_q == '0) ||
                        (max_nodes_q == '0) || (max_items_q == '0) ||
                        (max_str_q == '0) || (max_total_q == '0);
  assign is_arr_op    = (in_data_i.action == jslc_pkg::ACT_OPEN_ARR) ||
                        (in_data_i.action == jslc_pkg::ACT_CLOSE_ARR);

  always_comb begin
    if (!node_ok) begin
      cv_code = jslc_pkg::FAIL_NODES;
    end else if (bump_top && !items_ok) begin
      cv_code = jslc_pkg::FAIL_ITEMS;
    end else begin
      cv_code = jslc_pkg::FAIL_NONE;
    end
    if (in_data_i.length > max_str_q) begin
      text_code = jslc_pkg::FAIL_STRING;
    end else if (str_sum > (LW + 1)'(eff_total)) begin
      text_code = jslc_pkg::FAIL_TOTAL_STR;
    end else begin
      text_code = jslc_pkg::FAIL_NONE;
    end
  end

  always_comb begin
    depth_d     = depth_q;
    node_d      = node_q;
    str_d       = str_q;
    fail_d      = fail_q;
    offs_d      = offs_q;
    top_arr_d   = top_arr_q;
    top_items_d = top_items_q;
    under_d     = under_q;
    under_ram_d = under_ram_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_waddr   = AW'(depth_q - DW'(1));
    ram_raddr   = AW'(depth_q - DW'(3));
    ram_wdata   = {top_arr_q, items_bumped};

    if (in_fire) begin
      if (in_data_i.action == jslc_pkg::ACT_BEGIN) begin
        depth_d     = '0;
        node_d      = '0;
        str_d       = '0;
        offs_d      = '0;
        under_ram_d = 1'b0;
        if (bad_limits) begin
          fail_d = jslc_pkg::FAIL_BAD_LIMITS;
        end else if (in_data_i.length > max_bytes_q) begin
          fail_d = jslc_pkg::FAIL_TOO_LARGE;
        end else begin
          fail_d = jslc_pkg::FAIL_NONE;
        end
      end else if (fail_q == jslc_pkg::FAIL_NONE) begin
        case (in_data_i.action)
          jslc_pkg::ACT_SCALAR: begin
            if (cv_code != jslc_pkg::FAIL_NONE) begin
              fail_d = cv_code;
            end else begin
              node_d      = node_q + COUNT_BITS'(1);
              top_items_d = items_bumped;
            end
          end
          jslc_pkg::ACT_STRING: begin
            if (text_code != jslc_pkg::FAIL_NONE) begin
              fail_d = text_code;
            end else if (cv_code != jslc_pkg::FAIL_NONE) begin
              fail_d = cv_code;
            end else begin
              str_d       = COUNT_BITS'(str_sum);
              node_d      = node_q + COUNT_BITS'(1);
              top_items_d = items_bumped;
            end
          end
          jslc_pkg::ACT_KEY: begin
            if (depth_q == '0 || top_arr_q) begin
              fail_d = jslc_pkg::FAIL_KEY_PLACE;
            end else if (!items_ok) begin
              fail_d = jslc_pkg::FAIL_ITEMS;
            end else if (text_code != jslc_pkg::FAIL_NONE) begin
              fail_d = text_code;
            end else begin
              top_items_d = top_items_q + COUNT_BITS'(1);
              str_d       = COUNT_BITS'(str_sum);
            end
          end
          jslc_pkg::ACT_OPEN_OBJ, jslc_pkg::ACT_OPEN_ARR: begin
            if (cv_code != jslc_pkg::FAIL_NONE) begin
              fail_d = cv_code;
            end else if (depth_full) begin
              fail_d = jslc_pkg::FAIL_DEPTH;
            end else if (in_data_i.count_known &&
                         (in_data_i.declared_count > max_items_q)) begin
              fail_d = jslc_pkg::FAIL_ITEMS;
            end else begin
              // push: spill the parent frame and keep a copy as the frame below
              node_d      = node_q + COUNT_BITS'(1);
              ram_we      = (depth_q != '0);
              under_d     = ram_wdata;
              under_ram_d = 1'b0;
              top_arr_d   = is_arr_op;
              top_items_d = '0;
              depth_d     = depth_q + DW'(1);
            end
          end
          jslc_pkg::ACT_CLOSE_OBJ, jslc_pkg::ACT_CLOSE_ARR: begin
            if (depth_q == '0 || (top_arr_q != is_arr_op)) begin
              fail_d = jslc_pkg::FAIL_MISMATCH;
            end else begin
              // pop: frame below becomes top, prefetch the one under it
              depth_d     = depth_q - DW'(1);
              top_arr_d   = under_val[FW-1];
              top_items_d = under_val[COUNT_BITS-1:0];
              ram_re      = 1'b1;
              under_ram_d = 1'b1;
            end
          end
          jslc_pkg::ACT_BINARY: fail_d = jslc_pkg::FAIL_BINARY;
          jslc_pkg::ACT_SYNTAX: begin
            fail_d = jslc_pkg::FAIL_SYNTAX;
            offs_d = in_data_i.position;
          end
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    res.ok            = (fail_d == jslc_pkg::FAIL_NONE);
    res.fail_code     = fail_d;
    res.fail_position = offs_d;
  end

  jslc_ram #(
    .WIDTH (FW),
    .DEPTH (STACK_DEPTH)
  ) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_bytes_q <= jslc_pkg::RstMaxBytes;
      max_depth_q <= jslc_pkg::RstMaxDepth;
      max_nodes_q <= jslc_pkg::RstMaxNodes;
      max_items_q <= jslc_pkg::RstMaxItems;
      max_str_q   <= jslc_pkg::RstMaxString;
      max_total_q <= jslc_pkg::RstMaxTotalStr;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        jslc_pkg::REG_MAX_BYTES:     max_bytes_q <= cfg_wdata_i;
        jslc_pkg::REG_MAX_DEPTH:     max_depth_q <= cfg_wdata_i[6:0];
        jslc_pkg::REG_MAX_NODES:     max_nodes_q <= cfg_wdata_i;
        jslc_pkg::REG_MAX_ITEMS:     max_items_q <= cfg_wdata_i;
        jslc_pkg::REG_MAX_STRING:    max_str_q   <= cfg_wdata_i;
        jslc_pkg::REG_MAX_TOTAL_STR: max_total_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q     <= '0;
      node_q      <= '0;
      str_q       <= '0;
      fail_q      <= jslc_pkg::FAIL_NONE;
      offs_q      <= '0;
      top_arr_q   <= 1'b0;
      top_items_q <= '0;
      under_ram_q <= 1'b0;
    end else begin
      depth_q     <= depth_d;
      node_q      <= node_d;
      str_q       <= str_d;
      fail_q      <= fail_d;
      offs_q      <= offs_d;
      top_arr_q   <= top_arr_d;
      top_items_q <= top_items_d;
      under_ram_q <= under_ram_d;
    end
  end

  always_ff @(posedge clk_i) begin
    under_q <= under_d;
  end

  // result register plus skid entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
      sv_q <= 1'b0;
    end else if (sv_q) begin
      if (out_fire) begin
        sv_q <= 1'b0;
      end
    end else if (in_fire) begin
      if (ov_q && !out_fire) begin
        sv_q <= 1'b1;
      end
      ov_q <= 1'b1;
    end else if (out_fire) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sv_q) begin
      if (out_fire) begin
        out_q <= skid_q;
      end
    end else if (in_fire) begin
      if (ov_q && !out_fire) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end
  end

  assign in_stall_o  = sv_q;
  assign out_valid_o = ov_q;
  assign out_data_o  = out_q;

  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    XW'(depth_q) <= XW'(STACK_DEPTH))
    else $error("open depth beyond stack");

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sv_q |-> ov_q)
    else $error("skid entry full while output register empty");

  a_begin_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (in_data_i.action == jslc_pkg::ACT_BEGIN)
    |=> (depth_q == '0) && (node_q == '0) && (str_q == '0))
    else $error("begin did not clear document state");

  a_fail_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fail_q != jslc_pkg::FAIL_NONE) &&
    !(in_fire && (in_data_i.action == jslc_pkg::ACT_BEGIN))
    |=> $stable(fail_q) && $stable(depth_q))
    else $error("failure state changed without begin");

endmodule

// File: sim/json_structure_limit_checker_test.sv
// Self-checking testbench for the JSON structure limit checker: random SAX events against a predictor.
module json_structure_limit_checker_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int StackSize = 64;
  localparam logic [3:0] ActUnused = 4'd15;
  localparam int PrintCap = 100;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  jslc_pkg::in_item_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  jslc_pkg::out_item_t out_data_o;
  logic cfg_we_i = 1'b0;
  logic [jslc_pkg::CfgIdxBits-1:0] cfg_idx_i = '0;
  logic [jslc_pkg::CfgDataBits-1:0] cfg_wdata_i = '0;

  // Limit copies seen by the predictor.
  logic [31:0] lim_bytes, lim_nodes, lim_items, lim_str, lim_total;
  logic [6:0] lim_depth;

  // Predicted document state.
  bit lvl_is_arr [StackSize];
  logic [31:0] lvl_count [StackSize];
  int nest;
  logic [31:0] value_count, text_bytes, doc_fail_pos;
  jslc_pkg::fail_e doc_fail;

  jslc_pkg::in_item_t event_q [$];
  jslc_pkg::out_item_t status_q [$];

  int mismatches, events_sent, results_checked, settings_used, queued;
  bit calm;
  logic [31:0] byte_span, len_span, item_span;
  int gen_depth;

  json_structure_limit_checker dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_data_i(in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o(out_data_o),
    .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic flag_mismatch(input string msg);
    if (mismatches < PrintCap) $display("MISMATCH at status %0d: %s", results_checked, msg);
    mismatches++;
  endtask

  function automatic void note_fail(input jslc_pkg::fail_e code);
    if (doc_fail == jslc_pkg::FAIL_NONE) doc_fail = code;
  endfunction

  function automatic bit charge_item();
    if (lvl_count[nest-1] >= lim_items) begin
      note_fail(jslc_pkg::FAIL_ITEMS);
      return 1'b0;
    end
    lvl_count[nest-1] = lvl_count[nest-1] + 1;
    return 1'b1;
  endfunction

  function automatic bit charge_value();
    if (value_count >= lim_nodes) begin
      note_fail(jslc_pkg::FAIL_NODES);
      return 1'b0;
    end
    value_count = value_count + 1;
    if (nest > 0 && lvl_is_arr[nest-1]) return charge_item();
    return 1'b1;
  endfunction

  function automatic bit charge_text(input logic [31:0] len);
    if (len > lim_str) begin
      note_fail(jslc_pkg::FAIL_STRING);
      return 1'b0;
    end
    if (text_bytes > lim_total || len > lim_total - text_bytes) begin
      note_fail(jslc_pkg::FAIL_TOTAL_STR);
      return 1'b0;
    end
    text_bytes = text_bytes + len;
    return 1'b1;
  endfunction

  function automatic void push_level(input bit is_arr, input jslc_pkg::in_item_t ev);
    int dlim;
    dlim = (lim_depth < StackSize) ? int'(lim_depth) : StackSize;
    if (!charge_value()) return;
    if (nest >= dlim) begin
      note_fail(jslc_pkg::FAIL_DEPTH);
      return;
    end
    if (ev.count_known && ev.declared_count > lim_items) begin
      note_fail(jslc_pkg::FAIL_ITEMS);
      return;
    end
    lvl_is_arr[nest] = is_arr;
    lvl_count[nest] = '0;
    nest++;
  endfunction

  function automatic void pop_level(input bit is_arr);
    if (nest == 0 || lvl_is_arr[nest-1] != is_arr) note_fail(jslc_pkg::FAIL_MISMATCH);
    else nest--;
  endfunction

  // Advance the predicted state by one accepted event and queue its status.
  function automatic void track_event(input jslc_pkg::in_item_t ev);
    jslc_pkg::out_item_t st;
    if (ev.action == jslc_pkg::ACT_BEGIN) begin
      nest = 0;
      value_count = '0;
      text_bytes = '0;
      doc_fail = jslc_pkg::FAIL_NONE;
      doc_fail_pos = '0;
      if (lim_bytes == 0 || lim_depth == 0 || lim_nodes == 0 || lim_items == 0 ||
          lim_str == 0 || lim_total == 0)
        note_fail(jslc_pkg::FAIL_BAD_LIMITS);
      else if (ev.length > lim_bytes)
        note_fail(jslc_pkg::FAIL_TOO_LARGE);
    end else if (doc_fail == jslc_pkg::FAIL_NONE) begin
      case (ev.action)
        jslc_pkg::ACT_SCALAR: void'(charge_value());
        jslc_pkg::ACT_STRING: if (charge_text(ev.length)) void'(charge_value());
        jslc_pkg::ACT_KEY: begin
          if (nest == 0 || lvl_is_arr[nest-1]) note_fail(jslc_pkg::FAIL_KEY_PLACE);
          else if (charge_item()) void'(charge_text(ev.length));
        end
        jslc_pkg::ACT_OPEN_OBJ: push_level(1'b0, ev);
        jslc_pkg::ACT_OPEN_ARR: push_level(1'b1, ev);
        jslc_pkg::ACT_CLOSE_OBJ: pop_level(1'b0);
        jslc_pkg::ACT_CLOSE_ARR: pop_level(1'b1);
        jslc_pkg::ACT_BINARY: note_fail(jslc_pkg::FAIL_BINARY);
        jslc_pkg::ACT_SYNTAX: begin
          note_fail(jslc_pkg::FAIL_SYNTAX);
          doc_fail_pos = ev.position;
        end
        default: ;
      endcase
    end
    st.ok = (doc_fail == jslc_pkg::FAIL_NONE);
    st.fail_code = doc_fail;
    st.fail_position = doc_fail_pos;
    status_q = {status_q, st};
  endfunction

  // Driver: hold a stalled transfer, otherwise offer the next queued event or, at random, idle.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i <= '0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (in_valid_i) begin
        track_event(in_data_i);
        events_sent++;
      end
      if (event_q.size() != 0 && (calm || $urandom_range(99) >= 14)) begin
        in_valid_i <= 1'b1;
        in_data_i <= event_q.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Monitor: stall at random and check each status transfer.
  always @(posedge clk_i or negedge rst_ni) begin : watch_status
    jslc_pkg::out_item_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= !calm && ($urandom_range(99) < 14);
      if (out_valid_o && !out_stall_i) begin
        if (status_q.size() == 0) begin
          flag_mismatch("status transfer with nothing expected");
        end else begin
          want = status_q.pop_front();
          if (out_data_o.ok !== want.ok)
            flag_mismatch($sformatf("ok got %b want %b", out_data_o.ok, want.ok));
          if (out_data_o.fail_code !== want.fail_code)
            flag_mismatch($sformatf("fail_code got %0d want %0d",
                                    out_data_o.fail_code, want.fail_code));
          if (out_data_o.fail_position !== want.fail_position)
            flag_mismatch($sformatf("fail_position got %h want %h",
                                    out_data_o.fail_position, want.fail_position));
        end
        results_checked++;
      end
    end
  end

  task automatic put(input logic [3:0] act, input logic [31:0] len, input logic [31:0] decl,
                     input logic known, input logic [31:0] pos);
    jslc_pkg::in_item_t ev;
    ev.action = act;
    ev.length = len;
    ev.declared_count = decl;
    ev.count_known = known;
    ev.position = pos;
    event_q = {event_q, ev};
    queued++;
  endtask

  function automatic logic [31:0] pick_len(input logic [31:0] span);
    int r;
    r = $urandom_range(99);
    if (r < 80) return $urandom_range(span, 0);
    if (r < 95) return span + $urandom_range(2) - 1;
    return $urandom();
  endfunction

  function automatic jslc_pkg::in_item_t random_fields();
    jslc_pkg::in_item_t ev;
    ev.action = jslc_pkg::ACT_SCALAR;
    ev.length = pick_len(len_span);
    ev.declared_count = ($urandom_range(99) < 80) ? pick_len(item_span) : $urandom();
    ev.count_known = 1'($urandom_range(1));
    ev.position = $urandom();
    return ev;
  endfunction

  // Mostly well-formed document with random content and a little noise.
  task automatic queue_doc(input int n);
    int kinds [$];
    bit want_val;
    int pick;
    int last_kind;
    jslc_pkg::in_item_t ev;
    want_val = 1'b0;
    ev = random_fields();
    put(jslc_pkg::ACT_BEGIN, pick_len(byte_span), ev.declared_count, ev.count_known,
        ev.position);
    for (int k = 0; k < n; k++) begin
      ev = random_fields();
      pick = $urandom_range(99);
      if (pick < 6) begin
        ev.action = 4'($urandom_range(15, 1));
      end else if (kinds.size() != 0 && kinds[$] == 0 && !want_val) begin
        if (pick < 75) begin
          ev.action = jslc_pkg::ACT_KEY;
          want_val = 1'b1;
        end else begin
          ev.action = jslc_pkg::ACT_CLOSE_OBJ;
          kinds.delete(kinds.size() - 1);
        end
      end else begin
        want_val = 1'b0;
        if (pick < 30) begin
          ev.action = jslc_pkg::ACT_SCALAR;
        end else if (pick < 55) begin
          ev.action = jslc_pkg::ACT_STRING;
        end else if (pick < 70 && kinds.size() < gen_depth) begin
          ev.action = jslc_pkg::ACT_OPEN_OBJ;
          kinds = {kinds, 0};
        end else if (pick < 85 && kinds.size() < gen_depth) begin
          ev.action = jslc_pkg::ACT_OPEN_ARR;
          kinds = {kinds, 1};
        end else if (kinds.size() != 0 && kinds[$] == 1) begin
          ev.action = jslc_pkg::ACT_CLOSE_ARR;
          kinds.delete(kinds.size() - 1);
        end else begin
          ev.action = jslc_pkg::ACT_SCALAR;
        end
      end
      event_q = {event_q, ev};
      queued++;
    end
    while (kinds.size() != 0) begin
      last_kind = kinds[$];
      kinds.delete(kinds.size() - 1);
      put((last_kind != 0) ? jslc_pkg::ACT_CLOSE_ARR : jslc_pkg::ACT_CLOSE_OBJ,
          '0, '0, 1'b0, '0);
    end
  endtask

  task automatic queue_docs(input int count);
    int target;
    target = queued + count;
    while (queued < target) queue_doc($urandom_range(24, 4));
  endtask

  // Open a run of nested containers, then close them in reverse order.
  task automatic queue_nest(input int levels);
    put(jslc_pkg::ACT_BEGIN, '0, '0, 1'b0, '0);
    for (int k = 0; k < levels; k++)
      put((k % 2) ? jslc_pkg::ACT_OPEN_ARR : jslc_pkg::ACT_OPEN_OBJ, '0, $urandom(), 1'b0, '0);
    for (int k = levels - 1; k >= 0; k--)
      put((k % 2) ? jslc_pkg::ACT_CLOSE_ARR : jslc_pkg::ACT_CLOSE_OBJ, '0, '0, 1'b0, '0);
  endtask

  task automatic write_reg(input jslc_pkg::cfg_reg_e idx, input logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
  endtask

  task automatic set_limits(input logic [31:0] b, input logic [6:0] d, input logic [31:0] nd,
                            input logic [31:0] it, input logic [31:0] s, input logic [31:0] t);
    logic [31:0] depth_word;
    // Upper data bits of the depth write carry junk; only the low seven count.
    depth_word = {25'($urandom() >> 7), d};
    write_reg(jslc_pkg::REG_MAX_BYTES, b);
    write_reg(jslc_pkg::REG_MAX_DEPTH, depth_word);
    write_reg(jslc_pkg::REG_MAX_NODES, nd);
    write_reg(jslc_pkg::REG_MAX_ITEMS, it);
    write_reg(jslc_pkg::REG_MAX_STRING, s);
    write_reg(jslc_pkg::REG_MAX_TOTAL_STR, t);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    lim_bytes = b;
    lim_depth = d;
    lim_nodes = nd;
    lim_items = it;
    lim_str = s;
    lim_total = t;
    settings_used++;
  endtask

  task automatic drain();
    while (event_q.size() != 0 || in_valid_i || status_q.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  initial begin
    lim_bytes = jslc_pkg::RstMaxBytes;
    lim_depth = jslc_pkg::RstMaxDepth;
    lim_nodes = jslc_pkg::RstMaxNodes;
    lim_items = jslc_pkg::RstMaxItems;
    lim_str = jslc_pkg::RstMaxString;
    lim_total = jslc_pkg::RstMaxTotalStr;
    nest = 0;
    value_count = '0;
    text_bytes = '0;
    doc_fail = jslc_pkg::FAIL_NONE;
    doc_fail_pos = '0;
    settings_used = 1;
    calm = 1'b0;
    byte_span = 32'd2000000;
    len_span = 32'd200;
    item_span = 32'd5000;
    gen_depth = 6;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: events before any begin, limit edges, every action, most failure paths.
    put(jslc_pkg::ACT_SCALAR, '0, '0, 1'b0, '0);
    put(jslc_pkg::ACT_OPEN_ARR, '0, jslc_pkg::RstMaxItems, 1'b1, '0);
    put(jslc_pkg::ACT_CLOSE_ARR, '0, '0, 1'b0, '0);
    put(jslc_pkg::ACT_BEGIN, jslc_pkg::RstMaxBytes, '0, 1'b0, '0);
    put(jslc_pkg::ACT_OPEN_OBJ, '0, jslc_pkg::RstMaxItems, 1'b1, '0);
    put(jslc_pkg::ACT_KEY, jslc_pkg::RstMaxString, '0, 1'b0, '0);
    put(jslc_pkg::ACT_STRING, '0, '0, 1'b0, '0);
    put(jslc_pkg::ACT_KEY, '0, '0, 1'b0, '0);
    put(jslc_pkg::ACT_OPEN_ARR, '0, 32'hFFFF_FFFF, 1'b0, '0);
    put(jslc_pkg::ACT_SCALAR, '0, '0, 1'b0, '0);
    put(ActUnused, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
    put(jslc_pkg::ACT_CLOSE_ARR, '0, '0, 1'b0, '0);
    put(jslc_pkg::ACT_CLOSE_OBJ, '0, '0, 1'b0, '0);
    put(jslc_pkg::ACT_BEGIN, jslc_pkg::RstMaxBytes + 1, '0, 1'b0, '0);
    put(jslc_pkg::ACT_SCALAR, '0, '0, 1'b0, '0);
    put(jslc_pkg::ACT_BEGIN, '0, '0, 1'b0, '0);
    put(jslc_pkg::ACT_OPEN_ARR, '0, jslc_pkg::RstMaxItems + 1, 1'b1, '0);
    put(jslc_pkg::ACT_BEGIN, '0, '0, 1'b0, '0);
    put(jslc_pkg::ACT_KEY, '0, '0, 1'b0, '0);
    put(jslc_pkg::ACT_BEGIN, '0, '0, 1'b0, '0);
    put(jslc_pkg::ACT_OPEN_OBJ, '0, '0, 1'b0, '0);
    put(jslc_pkg::ACT_CLOSE_ARR, '0, '0, 1'b0, '0);
    put(jslc_pkg::ACT_BEGIN, '0, '0, 1'b0, '0);
    put(jslc_pkg::ACT_BINARY, '0, '0, 1'b0, '0);
    put(jslc_pkg::ACT_BEGIN, '0, '0, 1'b0, '0);
    put(jslc_pkg::ACT_SYNTAX, '0, '0, 1'b0, 32'hFFFF_FFFF);
    put(jslc_pkg::ACT_BEGIN, '0, '0, 1'b0, '0);
    put(jslc_pkg::ACT_STRING, jslc_pkg::RstMaxString + 1, '0, 1'b0, '0);
    queue_nest(StackSize);
    queue_nest(StackSize + 1);
    queue_docs(70);
    drain();

    // Tight limits: most documents trip one check or another.
    set_limits(32'd200, 7'd3, 32'd12, 32'd3, 32'd16, 32'd40);
    byte_span = 32'd220;
    len_span = 32'd18;
    item_span = 32'd4;
    gen_depth = 4;
    queue_docs(50);
    drain();

    set_limits(32'd1, 7'd1, 32'd1, 32'd1, 32'd1, 32'd1);
    byte_span = 32'd2;
    len_span = 32'd2;
    item_span = 32'd2;
    gen_depth = 2;
    queue_docs(20);
    drain();

    // Widest limits; a depth register above the stack size is held to the stack.
    calm = 1'b1;
    set_limits(32'hFFFF_FFFF, 7'd127, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
               32'hFFFF_FFFF);
    byte_span = 32'hFFFF_FFFF;
    len_span = 32'd5000;
    item_span = 32'd10;
    gen_depth = 8;
    queue_nest(StackSize + 1);
    queue_docs(30);
    drain();
    calm = 1'b0;

    // One zero register at a time makes the limits invalid.
    for (int z = 0; z < 6; z++) begin
      set_limits((z == 0) ? 32'd0 : 32'd100, (z == 1) ? 7'd0 : 7'd4,
                 (z == 2) ? 32'd0 : 32'd100, (z == 3) ? 32'd0 : 32'd100,
                 (z == 4) ? 32'd0 : 32'd100, (z == 5) ? 32'd0 : 32'd100);
      put(jslc_pkg::ACT_BEGIN, '0, '0, 1'b0, '0);
      put(jslc_pkg::ACT_SCALAR, '0, '0, 1'b0, '0);
      drain();
    end

    for (int p = 0; p < 3; p++) begin
      set_limits($urandom_range(5000, 1), 7'($urandom_range(8, 1)), $urandom_range(60, 1),
                 $urandom_range(10, 1), $urandom_range(100, 1), $urandom_range(400, 1));
      byte_span = lim_bytes;
      len_span = lim_str;
      item_span = lim_items;
      gen_depth = lim_depth + 1;
      queue_docs(20);
      drain();
    end

    repeat (5) @(posedge clk_i);
    $display("Sent %0d events under %0d limit settings; checked %0d status transfers.",
             events_sent, settings_used, results_checked);
    if (mismatches == 0 && status_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Timed out with %0d status transfers outstanding.", status_q.size());
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// File: sim.f
rtl/jslc_pkg.sv
rtl/jslc_ram.sv
rtl/json_structure_limit_checker.sv
sim/json_structure_limit_checker_test.sv
